// ===== hdl/ille_pkg.sv =====
// ----------------------------------------------------------------------------
// ille_pkg
// Shared types, sizes, operation and status codes for the list engine.
// ----------------------------------------------------------------------------
package ille_pkg;

    localparam int NODE_COUNT = 128;
    localparam int DATA_W     = 32;
    localparam int POS_W      = 7;
    localparam int CNT_W      = $clog2(NODE_COUNT + 1);
    localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam logic [2:0] OP_APPEND  = 3'd0;
    localparam logic [2:0] OP_INSERT  = 3'd1;
    localparam logic [2:0] OP_DELETE  = 3'd2;
    localparam logic [2:0] OP_REPLACE = 3'd3;
    localparam logic [2:0] OP_READ    = 3'd4;
    localparam logic [2:0] OP_CLEAR   = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_OOB   = 2'd3;

    typedef struct packed {
        logic [2:0]         opcode;
        logic [POS_W-1:0]   position;
        logic signed [31:0] value;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] read_value;
        logic [7:0]         length;
    } t_out_item;

    typedef struct packed {
        logic              ins;
        logic              del;
        logic              wr;
        logic              scan;
        logic [CMP_W-1:0]  pos;
        logic [DATA_W-1:0] val;
    } t_cell_cmd;

    function automatic logic [DATA_W-1:0] to_store(input logic [31:0] v);
        logic [63:0] tmp;
        tmp = 64'(v);
        return tmp[DATA_W-1:0];
    endfunction

    function automatic logic [31:0] from_store(input logic [DATA_W-1:0] d);
        logic [63:0] tmp;
        tmp = 64'(d);
        return tmp[31:0];
    endfunction

endpackage

// ===== hdl/ille_cell.sv =====
// ----------------------------------------------------------------------------
// ille_cell
// One list slot: holds the entry at its position, shifts with its neighbors
// on insert and delete, and forwards the read scan toward slot zero.
// ----------------------------------------------------------------------------
module ille_cell (
    input  logic                           i_clk,
    input  logic [ille_pkg::CMP_W-1:0]     i_index,
    input  ille_pkg::t_cell_cmd            i_cmd,
    input  logic [ille_pkg::DATA_W-1:0]    i_left_data,
    input  logic [ille_pkg::DATA_W-1:0]    i_right_data,
    input  logic [ille_pkg::DATA_W-1:0]    i_right_pass,
    output logic [ille_pkg::DATA_W-1:0]    o_data,
    output logic [ille_pkg::DATA_W-1:0]    o_pass
);
    import ille_pkg::*;

    logic [DATA_W-1:0] r_data;
    logic [DATA_W-1:0] r_pass;
    logic              w_hit;
    logic              w_above;

    assign w_hit   = (i_index == i_cmd.pos);
    assign w_above = (i_index > i_cmd.pos);

    always_ff @(posedge i_clk) begin
        if (i_cmd.ins) begin
            if (w_above) begin
                r_data <= i_left_data;
            end else if (w_hit) begin
                r_data <= i_cmd.val;
            end
        end else if (i_cmd.del) begin
            if (w_above || w_hit) begin
                r_data <= i_right_data;
            end
        end else if (i_cmd.wr) begin
            if (w_hit) begin
                r_data <= i_cmd.val;
            end
        end
        if (i_cmd.scan) begin
            r_pass <= w_hit ? r_data : i_right_pass;
        end
    end

    assign o_data = r_data;
    assign o_pass = r_pass;

endmodule

// ===== hdl/indexed_linked_list_engine.sv =====
// ----------------------------------------------------------------------------
// indexed_linked_list_engine
// Positional list of up to NODE_COUNT words with append, insert, delete,
// replace, read and clear; one result item per input item.
// ----------------------------------------------------------------------------
// The list lives in a row of slot cells, entry k in slot k. Append, insert,
// delete, replace and clear finish in the execute state: slots shift from
// their neighbors or load the new word at once; clear only resets the count.
// A read moves the selected word down the cell chain one slot per cycle. A new
// item is taken while the previous result still waits in the output register.
module indexed_linked_list_engine (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  ille_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output ille_pkg::t_out_item  o_out_item
);
    import ille_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]       r_state, n_state;
    t_in_item         r_item, n_item;
    logic [CNT_W-1:0] r_count, n_count;
    logic [POS_W-1:0] r_cnt, n_cnt;
    t_out_item        r_res, n_res;
    logic             r_out_valid, n_out_valid;
    t_out_item        r_out_item, n_out_item;

    t_cell_cmd        w_cmd;
    logic [CMP_W-1:0] w_pos_ext;
    logic [CMP_W-1:0] w_count_ext;
    logic [DATA_W-1:0] w_data [NODE_COUNT];
    logic [DATA_W-1:0] w_pass [NODE_COUNT];

    assign w_pos_ext   = CMP_W'(r_item.position);
    assign w_count_ext = CMP_W'(r_count);

    genvar gi;
    generate
        for (gi = 0; gi < NODE_COUNT; gi++) begin : g_cell
            logic [DATA_W-1:0] w_left;
            logic [DATA_W-1:0] w_right;
            logic [DATA_W-1:0] w_right_pass;
            if (gi == 0) begin : g_first
                assign w_left = '0;
            end else begin : g_mid
                assign w_left = w_data[gi-1];
            end
            if (gi == NODE_COUNT - 1) begin : g_last
                assign w_right      = '0;
                assign w_right_pass = '0;
            end else begin : g_inner
                assign w_right      = w_data[gi+1];
                assign w_right_pass = w_pass[gi+1];
            end
            ille_cell u_cell (
                .i_clk        (i_clk),
                .i_index      (CMP_W'(gi)),
                .i_cmd        (w_cmd),
                .i_left_data  (w_left),
                .i_right_data (w_right),
                .i_right_pass (w_right_pass),
                .o_data       (w_data[gi]),
                .o_pass       (w_pass[gi])
            );
        end
    endgenerate

    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_count     = r_count;
        n_cnt       = r_cnt;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out_item  = r_out_item;
        w_cmd       = '0;
        w_cmd.pos   = w_pos_ext;
        w_cmd.val   = to_store(r_item.value);

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_item  = i_in_item;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_res.status     = ST_OK;
                n_res.read_value = '0;
                n_state          = S_DONE;
                case (r_item.opcode)
                    OP_APPEND, OP_INSERT: begin
                        if (r_count == CNT_W'(NODE_COUNT)) begin
                            n_res.status = ST_FULL;
                        end else if (r_item.opcode == OP_INSERT &&
                                     w_pos_ext > w_count_ext) begin
                            n_res.status = ST_OOB;
                        end else begin
                            w_cmd.ins = 1'b1;
                            if (r_item.opcode == OP_APPEND) begin
                                w_cmd.pos = w_count_ext;
                            end
                            n_count = r_count + 1'b1;
                        end
                    end
                    OP_DELETE: begin
                        if (r_count == '0) begin
                            n_res.status = ST_EMPTY;
                        end else if (w_pos_ext >= w_count_ext) begin
                            n_res.status = ST_OOB;
                        end else begin
                            w_cmd.del = 1'b1;
                            n_count   = r_count - 1'b1;
                        end
                    end
                    OP_REPLACE: begin
                        if (w_pos_ext >= w_count_ext) begin
                            n_res.status = ST_OOB;
                        end else begin
                            w_cmd.wr = 1'b1;
                        end
                    end
                    OP_READ: begin
                        if (w_pos_ext >= w_count_ext) begin
                            n_res.status = ST_OOB;
                        end else begin
                            w_cmd.scan = 1'b1;
                            n_cnt      = r_item.position;
                            n_state    = S_SCAN;
                        end
                    end
                    OP_CLEAR: begin
                        n_count = '0;
                    end
                    default: begin
                    end
                endcase
                n_res.length = 8'(n_count);
            end
            S_SCAN: begin
                if (r_cnt == '0) begin
                    n_res.read_value = from_store(w_pass[0]);
                    n_state          = S_DONE;
                end else begin
                    w_cmd.scan = 1'b1;
                    n_cnt      = r_cnt - 1'b1;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_item  = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item     <= n_item;
        r_cnt      <= n_cnt;
        r_res      <= n_res;
        r_out_item <= n_out_item;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
